// ----- src/u8u16_pkg.sv -----
// shared types, constants and helpers for the utf-8 to utf-16 transcoder
// no dependencies; imported by every module of the block

package u8u16_pkg;

    localparam int BYTE_W     = 8;
    localparam int POINT_W    = 21;
    localparam int UNIT_W     = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [POINT_W-1:0] t_point;
    typedef logic [UNIT_W-1:0]  t_unit;

    localparam t_point POINT_BASE = 21'h010000;
    localparam t_unit  HIGH_BASE  = 16'hD800;
    localparam t_unit  LOW_BASE   = 16'hDC00;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    typedef struct packed {
        logic   valid;
        t_point point;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_point point;
    } t_head;

    function automatic t_lead classify(input t_byte b);
        t_lead kind;
        case (b) inside
            8'b0???????: kind = LEAD_ASCII;
            8'b110?????: kind = LEAD_TWO;
            8'b1110????: kind = LEAD_THREE;
            8'b11110???: kind = LEAD_FOUR;
            default:     kind = LEAD_BAD;
        endcase
        return kind;
    endfunction

endpackage

// ----- src/u8u16_ifs.sv -----
// valid/ready channel interfaces for the byte input and the code unit output
// depends on u8u16_pkg

interface u8u16_in_if;
    logic                 valid;
    logic                 ready;
    u8u16_pkg::t_byte     in_byte;
    logic                 end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8u16_out_if;
    logic                 valid;
    logic                 ready;
    u8u16_pkg::t_unit     code_unit;
    logic                 last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ----- src/u8u16_front.sv -----
// front end: accepts utf-8 bytes, tracks the open sequence, pushes complete code points
// depends on u8u16_pkg and u8u16_in_if

module u8u16_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    u8u16_in_if.sink             i_in,
    input  logic                 i_full,
    output u8u16_pkg::t_push     o_push
);
    import u8u16_pkg::*;

    t_point      r_partial, n_partial;
    logic [1:0]  r_left, n_left;
    logic        accept;
    logic        complete;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        complete  = 1'b0;
        if (accept) begin
            if (r_left == 2'd0) begin
                unique case (classify(i_in.in_byte))
                    LEAD_ASCII: begin
                        n_partial = POINT_W'(i_in.in_byte);
                        complete  = 1'b1;
                    end
                    LEAD_TWO: begin
                        n_partial = POINT_W'(i_in.in_byte[4:0]);
                        n_left    = 2'd1;
                    end
                    LEAD_THREE: begin
                        n_partial = POINT_W'(i_in.in_byte[3:0]);
                        n_left    = 2'd2;
                    end
                    LEAD_FOUR: begin
                        n_partial = POINT_W'(i_in.in_byte[2:0]);
                        n_left    = 2'd3;
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_partial = {r_partial[POINT_W-7:0], i_in.in_byte[5:0]};
                n_left    = r_left - 2'd1;
                complete  = (r_left == 2'd1);
            end
        end
    end

    always_comb begin
        o_push.valid = complete;
        o_push.point = n_partial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= '0;
        end else if (accept && i_in.end_of_text) begin
            r_partial <= '0;
            r_left    <= '0;
        end else begin
            r_partial <= complete ? '0 : n_partial;
            r_left    <= n_left;
        end
    end

endmodule

// ----- src/u8u16_queue.sv -----
// short queue of complete code points between front and back end
// depends on u8u16_pkg

module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8u16_pkg::t_push     i_push,
    input  logic                 i_pop,
    output logic                 o_full,
    output u8u16_pkg::t_head     o_head
);
    import u8u16_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_point              r_mem [DEPTH];
    logic [IDX_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                do_push, do_pop;

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.point = r_mem[r_rd_ptr];
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("code point pushed into full queue");

endmodule

// ----- src/u8u16_back.sv -----
// back end: pops code points, splits large ones into surrogate pairs, drives output register
// depends on u8u16_pkg and u8u16_out_if

module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8u16_pkg::t_head     i_head,
    output logic                 o_pop,
    u8u16_out_if.source          o_out
);
    import u8u16_pkg::*;

    logic    r_out_valid, n_out_valid;
    t_unit   r_out_unit, n_out_unit;
    logic    r_out_last, n_out_last;
    logic    r_low_pend, n_low_pend;
    t_unit   r_low_unit, n_low_unit;
    logic    take;
    logic    is_pair;
    t_point  adj;
    t_unit   high_unit;
    t_unit   low_unit;

    assign take      = !r_out_valid || o_out.ready;
    assign o_pop     = take && !r_low_pend && i_head.valid;
    assign is_pair   = |i_head.point[POINT_W-1:UNIT_W];
    assign adj       = i_head.point - POINT_BASE;
    assign high_unit = HIGH_BASE + UNIT_W'(adj[POINT_W-1:10]);
    assign low_unit  = LOW_BASE + UNIT_W'(adj[9:0]);

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_unit  = r_out_unit;
        n_out_last  = r_out_last;
        n_low_pend  = r_low_pend;
        n_low_unit  = r_low_unit;
        if (take) begin
            if (r_low_pend) begin
                n_out_valid = 1'b1;
                n_out_unit  = r_low_unit;
                n_out_last  = 1'b1;
                n_low_pend  = 1'b0;
            end else if (i_head.valid) begin
                n_out_valid = 1'b1;
                if (is_pair) begin
                    n_out_unit = high_unit;
                    n_out_last = 1'b0;
                    n_low_pend = 1'b1;
                    n_low_unit = low_unit;
                end else begin
                    n_out_unit = i_head.point[UNIT_W-1:0];
                    n_out_last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_unit <= n_out_unit;
        r_out_last <= n_out_last;
        r_low_unit <= n_low_unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_low_pend  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_low_pend  <= n_low_pend;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.code_unit = r_out_unit;
    assign o_out.last_unit = r_out_last;

    a_low_follows_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_pend |-> (r_out_valid && !r_out_last))
        else $error("low surrogate pending without high surrogate on output");

    a_no_pop_during_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_pend |-> !o_pop)
        else $error("queue popped while low surrogate pending");

endmodule

// ----- src/utf8_to_utf16_transcoder_top.sv -----
// top level of the utf-8 to utf-16 transcoder: front end, point queue, back end
// depends on u8u16_pkg, u8u16_ifs, u8u16_front, u8u16_queue, u8u16_back
//
//  port     dir  payload                         request
//  i_in     in   in_byte[7:0], end_of_text       one utf-8 byte
//  o_out    out  code_unit[15:0], last_unit      one utf-16 code unit
//
// one byte per cycle unless the queue is full; a point crosses queue and output register
// a code point above 0xffff gives two output units (high then low surrogate)
// the point queue of QUEUE_DEPTH entries absorbs low surrogate slots and output stalls
// the input stalls only when the queue is full
// synchronous active-low reset clears the open sequence, the queue and the output register

module utf8_to_utf16_transcoder_top #(
    parameter int QUEUE_DEPTH = u8u16_pkg::DEF_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8u16_in_if.sink     i_in,
    u8u16_out_if.source  o_out
);
    import u8u16_pkg::*;

    t_push  push;
    t_head  head;
    logic   full;
    logic   pop;

    u8u16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    u8u16_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
